// ===== rtl/core/hfa_pkg.sv =====
// hfa_pkg: shared types and constants of the first-fit heap allocator.
// Used by hfa_ctrl and first_fit_heap_allocator; depends on nothing.
package hfa_pkg;

  localparam int HEAP_BYTES_DEF   = 1024;
  localparam int HEADER_BYTES_DEF = 16;

  // fixed request / result field widths
  localparam int SIZE_FW = 11;
  localparam int ADDR_FW = 10;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic {
    ST_DONE  = 1'b0,
    ST_NOFIT = 1'b1
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [SIZE_FW-1:0] req_size;
    logic [ADDR_FW-1:0] block_addr;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [ADDR_FW-1:0] payload_addr;
  } rsp_t;

  // sequencer states
  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_A_START,
    S_A_CHK,
    S_A_FIT,
    S_A_WHOLE,
    S_A_SPL1,
    S_A_SPL2,
    S_A_SPL3,
    S_LINK,
    S_F_START,
    S_F_HSZ,
    S_F_HEND,
    S_F_EVAL,
    S_F_NEXT,
    S_F_ADJN,
    S_F_MRGN,
    S_F_MRGN2,
    S_F_ADJP,
    S_F_ADJP2,
    S_F_MP,
    S_F_MP2,
    S_F_PUT,
    S_RESP
  } state_t;

  // sequencer status seen by the top level
  typedef struct packed {
    logic clearing;
    logic busy;
  } ctrl_stat_t;

endpackage

// ===== rtl/core/hfa_alu.sv =====
// hfa_alu: shared add/subtract unit with a compare of its result.
// Depends on nothing; operands are muxed in by hfa_ctrl.
module hfa_alu #(
  parameter int CW = 13
) (
  input  logic          sub,
  input  logic [CW-1:0] a,
  input  logic [CW-1:0] b,
  input  logic [CW-1:0] c,
  output logic [CW-1:0] res,
  output logic          lt,
  output logic          eq
);

  // result and its relation to the compare operand
  assign res = sub ? (a - b) : (a + b);
  assign lt  = (res < c);
  assign eq  = (res == c);

endmodule

// ===== rtl/core/hfa_hdr_ram.sv =====
// hfa_hdr_ram: header store, one word {size, next} per byte offset.
// One write and one registered read port; no dependencies.
module hfa_hdr_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int SW    = 11,
  parameter int PW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [SW-1:0] wsize,
  input  logic [PW-1:0] wnext,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [SW-1:0] rsize,
  output logic [PW-1:0] rnext
);

  logic [SW+PW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wsize, wnext};
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      {rsize, rnext} <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/hfa_ctrl.sv =====
// hfa_ctrl: sequencer of the allocator, free-list walk, split and coalesce.
// Depends on hfa_pkg; drives hfa_alu operands and hfa_hdr_ram ports.
module hfa_ctrl #(
  parameter int HEAP_BYTES   = hfa_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = hfa_pkg::HEADER_BYTES_DEF,
  parameter int AW           = $clog2(HEAP_BYTES),
  parameter int PW           = AW + 1,
  parameter int SW           = AW + 1,
  parameter int CW           = ((PW > hfa_pkg::SIZE_FW) ? PW : hfa_pkg::SIZE_FW) + 2
) (
  input  logic                clk,
  input  logic                rst,
  // request / response words
  input  logic                req_valid,
  output logic                req_stall,
  input  hfa_pkg::req_t       req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output hfa_pkg::rsp_t       rsp,
  // shared unit
  output logic                alu_sub,
  output logic [CW-1:0]       alu_a,
  output logic [CW-1:0]       alu_b,
  output logic [CW-1:0]       alu_c,
  input  logic [CW-1:0]       alu_res,
  input  logic                alu_lt,
  input  logic                alu_eq,
  // header store
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [SW-1:0]       mem_wsize,
  output logic [PW-1:0]       mem_wnext,
  output logic                mem_re,
  output logic [AW-1:0]       mem_raddr,
  input  logic [SW-1:0]       mem_rsize,
  input  logic [PW-1:0]       mem_rnext,
  output hfa_pkg::ctrl_stat_t stat
);

  localparam int STW = $clog2(HEAP_BYTES + 2);
  localparam logic [PW-1:0]  LIST_END = PW'(HEAP_BYTES);
  localparam logic [CW-1:0]  HDR_C    = CW'(HEADER_BYTES);
  localparam logic [CW-1:0]  HEAP_C   = CW'(HEAP_BYTES);
  localparam logic [STW-1:0] STEP_MAX = STW'(HEAP_BYTES);
  localparam logic [AW-1:0]  LAST_OFF = AW'(HEAP_BYTES - 1);
  localparam logic [SW-1:0]  WHOLE_SZ = SW'(HEAP_BYTES - HEADER_BYTES);

  hfa_pkg::state_t state, state_next;

  logic [AW-1:0]  clr_cnt, clr_cnt_next;
  logic [PW-1:0]  free_head, free_head_next;
  logic [PW-1:0]  cur, cur_next;
  logic [PW-1:0]  prev, prev_next;
  logic           has_prev, has_prev_next;
  logic [SW-1:0]  prev_size, prev_size_next;
  logic [STW-1:0] steps, steps_next;
  logic [hfa_pkg::SIZE_FW-1:0] req_r, req_r_next;
  logic [hfa_pkg::ADDR_FW-1:0] addr_r, addr_r_next;
  logic [PW-1:0]  hdr, hdr_next;
  logic [CW-1:0]  fsize, fsize_next;
  logic [CW-1:0]  tmp, tmp_next;
  logic [CW-1:0]  hend, hend_next;
  logic [CW-1:0]  diff, diff_next;
  logic [PW-1:0]  nxt, nxt_next;
  logic [CW-1:0]  tgt, tgt_next;
  logic [CW-1:0]  pay, pay_next;
  hfa_pkg::status_t status_r, status_r_next;
  logic           ovalid, ovalid_next;
  hfa_pkg::rsp_t  rsp_r, rsp_r_next;

  logic           accept;
  logic           out_free;
  logic [CW-1:0]  cur_w, hdr_w, req_w, addr_w, rsize_w, prev_w, psize_w;
  logic [STW-1:0] steps_inc;

  function automatic logic in_heap(input logic [CW-1:0] x);
    return x < HEAP_C;
  endfunction

  // end-of-list encoding for anything outside the heap
  function automatic logic [PW-1:0] norm(input logic [CW-1:0] x);
    return (x < HEAP_C) ? x[PW-1:0] : LIST_END;
  endfunction

  assign cur_w     = CW'(cur);
  assign hdr_w     = CW'(hdr);
  assign req_w     = CW'(req_r);
  assign addr_w    = CW'(addr_r);
  assign rsize_w   = CW'(mem_rsize);
  assign prev_w    = CW'(prev);
  assign psize_w   = CW'(prev_size);
  assign steps_inc = steps + STW'(1);

  assign accept    = req_valid && !req_stall;
  assign out_free  = !ovalid || !rsp_stall;
  assign req_stall = (state != hfa_pkg::S_IDLE);
  assign rsp_valid = ovalid;
  assign rsp       = rsp_r;
  assign stat.clearing = (state == hfa_pkg::S_CLEAR);
  assign stat.busy     = (state != hfa_pkg::S_IDLE);

  // shared unit operand selection
  always_comb begin
    alu_sub = 1'b0;
    alu_a   = '0;
    alu_b   = '0;
    alu_c   = '0;
    unique case (state)
      hfa_pkg::S_A_CHK:   begin alu_a = rsize_w; alu_c = req_w; end
      hfa_pkg::S_A_FIT:   begin
        alu_sub = 1'b1; alu_a = fsize; alu_b = req_w; alu_c = HDR_C + CW'(1);
      end
      hfa_pkg::S_A_WHOLE,
      hfa_pkg::S_A_SPL1:  begin alu_a = cur_w; alu_b = HDR_C; end
      hfa_pkg::S_A_SPL2:  begin alu_a = pay; alu_b = req_w; end
      hfa_pkg::S_A_SPL3:  begin alu_sub = 1'b1; alu_a = diff; alu_b = HDR_C; end
      hfa_pkg::S_F_START: begin
        alu_sub = 1'b1; alu_a = addr_w; alu_b = HDR_C; alu_c = HEAP_C;
      end
      hfa_pkg::S_F_HSZ:   begin alu_a = hdr_w; alu_b = HDR_C; end
      hfa_pkg::S_F_HEND:  begin alu_a = tmp; alu_b = fsize; end
      hfa_pkg::S_F_EVAL:  begin alu_a = cur_w; alu_c = hdr_w; end
      hfa_pkg::S_F_ADJN:  begin alu_a = hend; alu_c = cur_w; end
      hfa_pkg::S_F_MRGN:  begin alu_a = rsize_w; alu_b = HDR_C; end
      hfa_pkg::S_F_MRGN2: begin alu_a = fsize; alu_b = tmp; end
      hfa_pkg::S_F_ADJP:  begin alu_a = prev_w; alu_b = HDR_C; end
      hfa_pkg::S_F_ADJP2: begin alu_a = tmp; alu_b = psize_w; alu_c = hdr_w; end
      hfa_pkg::S_F_MP:    begin alu_a = psize_w; alu_b = HDR_C; end
      hfa_pkg::S_F_MP2:   begin alu_a = tmp; alu_b = fsize; end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      hfa_pkg::S_CLEAR:
        if (clr_cnt == LAST_OFF) state_next = hfa_pkg::S_IDLE;
      hfa_pkg::S_IDLE:
        if (accept) begin
          state_next = (req.kind == hfa_pkg::KIND_FREE) ? hfa_pkg::S_F_START
                                                        : hfa_pkg::S_A_START;
        end
      hfa_pkg::S_A_START:
        state_next = in_heap(CW'(free_head)) ? hfa_pkg::S_A_CHK : hfa_pkg::S_RESP;
      hfa_pkg::S_A_CHK:
        if (!alu_lt) begin
          state_next = hfa_pkg::S_A_FIT;
        end else if (steps_inc > STEP_MAX || !in_heap(CW'(mem_rnext))) begin
          state_next = hfa_pkg::S_RESP;
        end
      hfa_pkg::S_A_FIT:
        state_next = alu_lt ? hfa_pkg::S_A_WHOLE : hfa_pkg::S_A_SPL1;
      hfa_pkg::S_A_WHOLE: state_next = hfa_pkg::S_LINK;
      hfa_pkg::S_A_SPL1:  state_next = hfa_pkg::S_A_SPL2;
      hfa_pkg::S_A_SPL2:  state_next = hfa_pkg::S_A_SPL3;
      hfa_pkg::S_A_SPL3:  state_next = hfa_pkg::S_LINK;
      hfa_pkg::S_LINK:    state_next = hfa_pkg::S_RESP;
      hfa_pkg::S_F_START:
        if (addr_w < HDR_C || !alu_lt) state_next = hfa_pkg::S_RESP;
        else state_next = hfa_pkg::S_F_HSZ;
      hfa_pkg::S_F_HSZ:   state_next = hfa_pkg::S_F_HEND;
      hfa_pkg::S_F_HEND:  state_next = hfa_pkg::S_F_EVAL;
      hfa_pkg::S_F_EVAL:
        if (in_heap(cur_w) && alu_lt) begin
          state_next = (steps_inc > STEP_MAX) ? hfa_pkg::S_RESP : hfa_pkg::S_F_NEXT;
        end else if (alu_eq) begin
          state_next = hfa_pkg::S_RESP;
        end else begin
          state_next = hfa_pkg::S_F_ADJN;
        end
      hfa_pkg::S_F_NEXT:  state_next = hfa_pkg::S_F_EVAL;
      hfa_pkg::S_F_ADJN:
        state_next = (in_heap(cur_w) && alu_eq) ? hfa_pkg::S_F_MRGN : hfa_pkg::S_F_ADJP;
      hfa_pkg::S_F_MRGN:  state_next = hfa_pkg::S_F_MRGN2;
      hfa_pkg::S_F_MRGN2: state_next = hfa_pkg::S_F_ADJP;
      hfa_pkg::S_F_ADJP:
        state_next = has_prev ? hfa_pkg::S_F_ADJP2 : hfa_pkg::S_F_PUT;
      hfa_pkg::S_F_ADJP2:
        state_next = alu_eq ? hfa_pkg::S_F_MP : hfa_pkg::S_F_PUT;
      hfa_pkg::S_F_MP:    state_next = hfa_pkg::S_F_MP2;
      hfa_pkg::S_F_MP2:   state_next = hfa_pkg::S_RESP;
      hfa_pkg::S_F_PUT:   state_next = hfa_pkg::S_LINK;
      hfa_pkg::S_RESP:
        if (out_free) state_next = hfa_pkg::S_IDLE;
      default: state_next = hfa_pkg::S_IDLE;
    endcase
  end

  // datapath registers and store ports
  always_comb begin
    clr_cnt_next   = clr_cnt;
    free_head_next = free_head;
    cur_next       = cur;
    prev_next      = prev;
    has_prev_next  = has_prev;
    prev_size_next = prev_size;
    steps_next     = steps;
    req_r_next     = req_r;
    addr_r_next    = addr_r;
    hdr_next       = hdr;
    fsize_next     = fsize;
    tmp_next       = tmp;
    hend_next      = hend;
    diff_next      = diff;
    nxt_next       = nxt;
    tgt_next       = tgt;
    pay_next       = pay;
    status_r_next  = status_r;
    ovalid_next    = ovalid && rsp_stall;
    rsp_r_next     = rsp_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wsize = '0;
    mem_wnext = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state)
      hfa_pkg::S_CLEAR: begin
        // sweep: whole-heap block at offset zero, zero elsewhere
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        if (clr_cnt == '0) begin
          mem_wsize = WHOLE_SZ;
          mem_wnext = LIST_END;
        end
        clr_cnt_next = clr_cnt + AW'(1);
      end
      hfa_pkg::S_IDLE:
        if (accept) begin
          req_r_next    = req.req_size;
          addr_r_next   = req.block_addr;
          pay_next      = '0;
          status_r_next = hfa_pkg::ST_DONE;
        end
      hfa_pkg::S_A_START: begin
        cur_next      = free_head;
        has_prev_next = 1'b0;
        steps_next    = '0;
        if (in_heap(CW'(free_head))) begin
          mem_re    = 1'b1;
          mem_raddr = free_head[AW-1:0];
        end else begin
          status_r_next = hfa_pkg::ST_NOFIT;
        end
      end
      hfa_pkg::S_A_CHK:
        if (alu_lt) begin
          // too small: step to the next free block
          steps_next = steps_inc;
          if (steps_inc > STEP_MAX || !in_heap(CW'(mem_rnext))) begin
            status_r_next = hfa_pkg::ST_NOFIT;
          end else begin
            prev_next      = cur;
            prev_size_next = mem_rsize;
            has_prev_next  = 1'b1;
            cur_next       = mem_rnext;
            mem_re         = 1'b1;
            mem_raddr      = mem_rnext[AW-1:0];
          end
        end else begin
          fsize_next = rsize_w;
          nxt_next   = mem_rnext;
        end
      hfa_pkg::S_A_FIT: diff_next = alu_res;
      hfa_pkg::S_A_WHOLE: begin
        mem_we    = 1'b1;
        mem_waddr = cur[AW-1:0];
        mem_wsize = fsize[SW-1:0];
        mem_wnext = LIST_END;
        pay_next  = alu_res;
        tgt_next  = CW'(nxt);
      end
      hfa_pkg::S_A_SPL1: begin
        mem_we    = 1'b1;
        mem_waddr = cur[AW-1:0];
        mem_wsize = req_w[SW-1:0];
        mem_wnext = LIST_END;
        pay_next  = alu_res;
      end
      hfa_pkg::S_A_SPL2: tgt_next = alu_res;
      hfa_pkg::S_A_SPL3: begin
        // tail header, dropped past the heap end
        mem_we    = in_heap(tgt);
        mem_waddr = tgt[AW-1:0];
        mem_wsize = alu_res[SW-1:0];
        mem_wnext = norm(CW'(nxt));
      end
      hfa_pkg::S_LINK:
        if (has_prev) begin
          mem_we    = 1'b1;
          mem_waddr = prev[AW-1:0];
          mem_wsize = prev_size;
          mem_wnext = norm(tgt);
        end else begin
          free_head_next = norm(tgt);
        end
      hfa_pkg::S_F_START: begin
        hdr_next = alu_res[PW-1:0];
        if (!(addr_w < HDR_C) && alu_lt) begin
          mem_re    = 1'b1;
          mem_raddr = alu_res[AW-1:0];
        end
      end
      hfa_pkg::S_F_HSZ: begin
        fsize_next    = rsize_w;
        tmp_next      = alu_res;
        cur_next      = free_head;
        steps_next    = '0;
        has_prev_next = 1'b0;
      end
      hfa_pkg::S_F_HEND: hend_next = alu_res;
      hfa_pkg::S_F_EVAL:
        if (in_heap(cur_w) && alu_lt) begin
          steps_next = steps_inc;
          if (!(steps_inc > STEP_MAX)) begin
            prev_next     = cur;
            has_prev_next = 1'b1;
            mem_re        = 1'b1;
            mem_raddr     = cur[AW-1:0];
          end
        end
      hfa_pkg::S_F_NEXT: begin
        cur_next       = mem_rnext;
        prev_size_next = mem_rsize;
      end
      hfa_pkg::S_F_ADJN:
        if (in_heap(cur_w) && alu_eq) begin
          mem_re    = 1'b1;
          mem_raddr = cur[AW-1:0];
        end
      hfa_pkg::S_F_MRGN: begin
        // absorb the following free block
        tmp_next = alu_res;
        cur_next = mem_rnext;
      end
      hfa_pkg::S_F_MRGN2: fsize_next = alu_res;
      hfa_pkg::S_F_ADJP:  tmp_next = alu_res;
      hfa_pkg::S_F_ADJP2: ;
      hfa_pkg::S_F_MP:    tmp_next = alu_res;
      hfa_pkg::S_F_MP2: begin
        // grow the previous free block over this one
        mem_we    = 1'b1;
        mem_waddr = prev[AW-1:0];
        mem_wsize = alu_res[SW-1:0];
        mem_wnext = norm(cur_w);
      end
      hfa_pkg::S_F_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = hdr[AW-1:0];
        mem_wsize = fsize[SW-1:0];
        mem_wnext = norm(cur_w);
        tgt_next  = hdr_w;
      end
      hfa_pkg::S_RESP:
        if (out_free) begin
          ovalid_next = 1'b1;
          rsp_r_next.status = status_r;
          rsp_r_next.payload_addr = (status_r == hfa_pkg::ST_NOFIT) ? '0
                                    : pay[hfa_pkg::ADDR_FW-1:0];
        end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hfa_pkg::S_CLEAR;
      clr_cnt   <= '0;
      free_head <= '0;
      ovalid    <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      free_head <= free_head_next;
      ovalid    <= ovalid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur       <= cur_next;
    prev      <= prev_next;
    has_prev  <= has_prev_next;
    prev_size <= prev_size_next;
    steps     <= steps_next;
    req_r     <= req_r_next;
    addr_r    <= addr_r_next;
    hdr       <= hdr_next;
    fsize     <= fsize_next;
    tmp       <= tmp_next;
    hend      <= hend_next;
    diff      <= diff_next;
    nxt       <= nxt_next;
    tgt       <= tgt_next;
    pay       <= pay_next;
    status_r  <= status_r_next;
    rsp_r     <= rsp_r_next;
  end

endmodule

// ===== rtl/core/first_fit_heap_allocator.sv =====
// first_fit_heap_allocator: top level, sequencer, shared adder and header store.
// Depends on hfa_pkg, hfa_alu, hfa_hdr_ram and hfa_ctrl.
//
//   channel | words  | handshake             | direction
//   req     | req_t  | req_valid / req_stall | in
//   rsp     | rsp_t  | rsp_valid / rsp_stall | out
//
// After reset a clearing pass writes every word of the header store while
// req_stall is held high. One word in, one word out, one at a time.
// Allocate walks the free list with one header read a cycle. Free walks it
// too; the shared adder and the single read port of the header store bound
// both walks. A waiting result does not block the next request; only the
// finish of that next request waits for rsp_stall.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = hfa_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = hfa_pkg::HEADER_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  hfa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output hfa_pkg::rsp_t rsp
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int PW = AW + 1;
  localparam int SW = AW + 1;
  localparam int CW = ((PW > hfa_pkg::SIZE_FW) ? PW : hfa_pkg::SIZE_FW) + 2;

  logic          alu_sub, alu_lt, alu_eq;
  logic [CW-1:0] alu_a, alu_b, alu_c, alu_res;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [SW-1:0] mem_wsize, mem_rsize;
  logic [PW-1:0] mem_wnext, mem_rnext;
  hfa_pkg::ctrl_stat_t stat;

  hfa_alu #(.CW(CW)) u_alu (
    .sub(alu_sub), .a(alu_a), .b(alu_b), .c(alu_c),
    .res(alu_res), .lt(alu_lt), .eq(alu_eq)
  );

  hfa_hdr_ram #(.DEPTH(HEAP_BYTES), .AW(AW), .SW(SW), .PW(PW)) u_ram (
    .clk(clk),
    .we(mem_we), .waddr(mem_waddr), .wsize(mem_wsize), .wnext(mem_wnext),
    .re(mem_re), .raddr(mem_raddr), .rsize(mem_rsize), .rnext(mem_rnext)
  );

  hfa_ctrl #(
    .HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES),
    .AW(AW), .PW(PW), .SW(SW), .CW(CW)
  ) u_ctrl (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .alu_sub(alu_sub), .alu_a(alu_a), .alu_b(alu_b), .alu_c(alu_c),
    .alu_res(alu_res), .alu_lt(alu_lt), .alu_eq(alu_eq),
    .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wsize(mem_wsize),
    .mem_wnext(mem_wnext), .mem_re(mem_re), .mem_raddr(mem_raddr),
    .mem_rsize(mem_rsize), .mem_rnext(mem_rnext),
    .stat(stat)
  );

`ifndef SYNTH
  // no request taken during the clearing pass
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    stat.clearing |-> req_stall)
    else $error("request accepted while clearing");

  // a no-fit answer carries a zero offset
  a_nofit_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == hfa_pkg::ST_NOFIT) |-> (rsp.payload_addr == '0))
    else $error("no-fit result with nonzero offset");

  // request stall follows the sequencer being busy
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    req_stall == stat.busy)
    else $error("request stall out of step with sequencer");
`endif

endmodule
